// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the grid hash compare checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle.
`define GHOD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid hash compare: same-cycle check failed");

// Implication into the next cycle.
`define GHOD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid hash compare: next-cycle check failed");

`endif

// ===== rtl/ghod_pkg.sv =====
// ----------------------------------------------------------------------------
// ghod_pkg
// Widths, limits, register indexes and shared types of the grid hash compare.
// ----------------------------------------------------------------------------
package ghod_pkg;

    localparam int DEF_MAX_ROWS  = 32;
    localparam int DEF_MAX_COLS  = 16;
    localparam int DEF_HASH_BITS = 64;

    localparam int HASH_W     = 64;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 4;
    localparam int CNT_W      = 10;
    localparam int SUM_W      = 16;
    localparam int AVG_W      = 15;
    localparam int RATIO_W    = 17;
    localparam int DIST_W     = 7;
    localparam int DIV_W      = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [AVG_W-1:0]   AVG_MAX   = '1;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREV_ROWS = 3'd0,
        CFG_PREV_COLS = 3'd1,
        CFG_CUR_COLS  = 3'd2,
        CFG_ROW_OFF   = 3'd3,
        CFG_THRESHOLD = 3'd4
    } t_cfg_idx;

    // Compare transaction moving down the distance pipeline.
    typedef struct packed {
        logic valid;
        logic cmp;
        logic last;
    } t_item;

    // Grid totals handed to the divider stage at the end of a grid.
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] compared;
        logic [CNT_W-1:0] matched;
        logic [SUM_W-1:0] total;
    } t_fin;

endpackage

// ===== rtl/ghod_store.sv =====
// ----------------------------------------------------------------------------
// ghod_store
// Previous-grid hash memory, one port, registered read data.
// ----------------------------------------------------------------------------
module ghod_store #(
    parameter int HASH_BITS = ghod_pkg::DEF_HASH_BITS,
    parameter int DEPTH     = ghod_pkg::DEF_MAX_ROWS * ghod_pkg::DEF_MAX_COLS,
    parameter int AW        = $clog2(ghod_pkg::DEF_MAX_ROWS * ghod_pkg::DEF_MAX_COLS)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_addr,
    input  logic [HASH_BITS-1:0] i_wdata,
    output logic [HASH_BITS-1:0] o_rdata
);
    import ghod_pkg::*;

    logic [HASH_BITS-1:0] r_mem [DEPTH];
    logic [HASH_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ghod_acc.sv =====
// ----------------------------------------------------------------------------
// ghod_acc
// Hamming distance pipeline and saturating grid accumulators.
// ----------------------------------------------------------------------------
module ghod_acc #(
    parameter int HASH_BITS = ghod_pkg::DEF_HASH_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ghod_pkg::t_item              i_item,
    input  logic [HASH_BITS-1:0]         i_hash,
    input  logic [HASH_BITS-1:0]         i_rdata,
    input  logic [ghod_pkg::DIST_W-1:0]  i_thr,
    output ghod_pkg::t_fin               o_fin
);
    import ghod_pkg::*;

    localparam int NCH = (HASH_BITS + 7) / 8;

    t_item                r_s1;
    t_item                r_s2;
    t_item                r_s3;
    logic [HASH_BITS-1:0] r_s1_hash;
    logic [NCH-1:0][3:0]  r_s2_part;
    logic [DIST_W-1:0]    r_s3_dist;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_mat;
    t_fin                 r_fin;

    logic [NCH*8-1:0]     w_xp;
    logic [NCH-1:0][3:0]  n_part;
    logic [DIST_W-1:0]    n_dist;
    logic [SUM_W:0]       w_sum_ext;
    logic [SUM_W-1:0]     n_sum;
    logic [CNT_W-1:0]     n_cnt;
    logic [CNT_W-1:0]     n_mat;

    assign w_xp = (NCH*8)'(i_rdata ^ r_s1_hash);

    // Count set bits a byte at a time.
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_part[c] = '0;
            for (int b = 0; b < 8; b++) begin
                n_part[c] = n_part[c] + 4'(w_xp[c*8+b]);
            end
        end
    end

    always_comb begin
        n_dist = '0;
        for (int k = 0; k < NCH; k++) begin
            n_dist = n_dist + DIST_W'(r_s2_part[k]);
        end
    end

    assign w_sum_ext = {1'b0, r_sum} + (SUM_W+1)'(r_s3_dist);

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_mat = r_mat;
        if (r_s3.valid && r_s3.cmp) begin
            n_sum = w_sum_ext[SUM_W] ? SUM_MAX : w_sum_ext[SUM_W-1:0];
            if (r_cnt != COUNT_MAX) begin
                n_cnt = r_cnt + 1'b1;
            end
            if ((r_s3_dist <= i_thr) && (r_mat != COUNT_MAX)) begin
                n_mat = r_mat + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hash <= i_hash;
        r_s2_part <= n_part;
        r_s3_dist <= n_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_s2  <= '0;
            r_s3  <= '0;
            r_sum <= '0;
            r_cnt <= '0;
            r_mat <= '0;
            r_fin <= '0;
        end else begin
            r_s1           <= i_item;
            r_s2           <= r_s1;
            r_s3           <= r_s2;
            r_fin.valid    <= r_s3.valid && r_s3.last;
            r_fin.compared <= n_cnt;
            r_fin.matched  <= n_mat;
            r_fin.total    <= n_sum;
            // Clear the totals once the closing cell has been folded in.
            if (r_s3.valid && r_s3.last) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_mat <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
                r_mat <= n_mat;
            end
        end
    end

    assign o_fin = r_fin;

endmodule

// ===== rtl/ghod_div.sv =====
// ----------------------------------------------------------------------------
// ghod_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ghod_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ghod_pkg::DIV_W-1:0]  i_dividend,
    input  logic [ghod_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [ghod_pkg::DIV_W-1:0]  o_quotient
);
    import ghod_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic              r_run;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W+1:0]  w_ext;
    logic [CNT_W+1:0]  w_sub;
    logic              w_take;

    assign w_ext  = {1'b0, r_rem, r_quo[DIV_W-1]};
    assign w_sub  = w_ext - {2'b00, r_div};
    assign w_take = !w_sub[CNT_W+1];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_rem <= w_take ? w_sub[CNT_W-1:0] : w_ext[CNT_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(DIV_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/grid_hash_offset_delta_core.sv =====
// ----------------------------------------------------------------------------
// grid_hash_offset_delta_core
// Loads a previous grid of cell hashes into memory, then compares each
// current cell with the stored cell one row offset away and reports the
// compared and matched counts, distance total, average and match ratio.
// Throughput: one cell per cycle while o_busy is low.
// After the last cell is taken, it passes the memory read and the popcount,
// distance and accumulate registers; then the divide is launched, the
// one-bit-per-cycle divider runs and the result register is loaded; o_busy
// stays high until the result strobe rises. Reset (synchronous, active low)
// clears control, config and total registers; the hash memory and data
// registers are not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module grid_hash_offset_delta_core #(
    parameter int MAX_ROWS  = ghod_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = ghod_pkg::DEF_MAX_COLS,
    parameter int HASH_BITS = ghod_pkg::DEF_HASH_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Cell transaction
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_kind,
    input  logic [ghod_pkg::ROW_W-1:0]       i_row,
    input  logic [ghod_pkg::COL_W-1:0]       i_col,
    input  logic [ghod_pkg::HASH_W-1:0]      i_hash,
    input  logic                             i_last,
    // Register write port
    input  logic                             i_cfg_we,
    input  logic [ghod_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ghod_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Result transaction
    output logic                             o_valid,
    output logic [ghod_pkg::CNT_W-1:0]       o_compared_cells,
    output logic [ghod_pkg::CNT_W-1:0]       o_matched_cells,
    output logic [ghod_pkg::SUM_W-1:0]       o_total_distance,
    output logic [ghod_pkg::AVG_W-1:0]       o_average_distance,
    output logic [ghod_pkg::RATIO_W-1:0]     o_match_ratio
);
    import ghod_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // One-hot sequencer: run cells, drain the pipe, divide.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_DIV   = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;

    // Registers written over the config port
    logic [5:0]        r_prev_rows;
    logic [4:0]        r_prev_cols;
    logic [4:0]        r_cur_cols;
    logic [5:0]        r_row_off;
    logic [DIST_W-1:0] r_thr;

    // Grid totals latched at the end of the grid
    t_fin              r_snap;

    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_cmp;
    logic [CNT_W-1:0]  r_out_mat;
    logic [SUM_W-1:0]  r_out_sum;
    logic [AVG_W-1:0]  r_out_avg;
    logic [RATIO_W-1:0] r_out_ratio;

    logic              w_acc;
    logic [6:0]        w_prow;
    logic              w_cmp_ok;
    logic              w_load_ok;
    logic [5:0]        w_arow;
    logic [31:0]       w_addr_full;
    logic [AW-1:0]     w_addr;
    t_item             w_item;
    t_fin              w_fin;
    logic [HASH_BITS-1:0] w_rdata;
    logic              w_avg_done;
    logic              w_rat_done;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_avg_q;
    logic [DIV_W-1:0]  w_rat_q;
    logic [AVG_W-1:0]  n_avg;
    logic [RATIO_W-1:0] n_ratio;

    assign o_busy = (r_state != ST_IDLE);
    assign w_acc  = i_start && !o_busy;

    // Previous row = current row + signed offset; -32..62 fits 7 bits signed.
    assign w_prow = 7'({2'b00, i_row}) + {r_row_off[5], r_row_off};

    // Compare only where the previous row exists and the column is shared.
    assign w_cmp_ok = !w_prow[6]
                   && (w_prow[5:0] < r_prev_rows)
                   && (32'(w_prow[5:0]) < MAX_ROWS)
                   && ({1'b0, i_col} < r_prev_cols)
                   && ({1'b0, i_col} < r_cur_cols)
                   && (32'(i_col) < MAX_COLS);

    // Drop loads that fall outside the memory.
    assign w_load_ok = (32'(i_row) < MAX_ROWS) && (32'(i_col) < MAX_COLS);

    assign w_arow      = i_kind ? w_prow[5:0] : {1'b0, i_row};
    assign w_addr_full = 32'(w_arow) * MAX_COLS + 32'(i_col);
    assign w_addr      = w_addr_full[AW-1:0];

    // Only compare transactions travel down the distance pipe; a closing
    // cell travels even when it is skipped so the totals still come out.
    assign w_item.valid = w_acc && i_kind;
    assign w_item.cmp   = w_cmp_ok;
    assign w_item.last  = i_last;

    ghod_store #(
        .HASH_BITS (HASH_BITS),
        .DEPTH     (DEPTH),
        .AW        (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_acc && !i_kind && w_load_ok),
        .i_re    (w_acc && i_kind && w_cmp_ok),
        .i_addr  (w_addr),
        .i_wdata (i_hash[HASH_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    ghod_acc #(
        .HASH_BITS (HASH_BITS)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .i_hash  (i_hash[HASH_BITS-1:0]),
        .i_rdata (w_rdata),
        .i_thr   (r_thr),
        .o_fin   (w_fin)
    );

    // Average in Q7.8 and ratio in Q1.16 run side by side in lockstep.
    ghod_div u_div_avg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_fin.valid),
        .i_dividend ({2'b00, w_fin.total, 8'h00}),
        .i_divisor  (w_fin.compared),
        .o_done     (w_avg_done),
        .o_quotient (w_avg_q)
    );

    ghod_div u_div_ratio (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_fin.valid),
        .i_dividend ({w_fin.matched, 16'h0000}),
        .i_divisor  (w_fin.compared),
        .o_done     (w_rat_done),
        .o_quotient (w_rat_q)
    );

    assign w_div_done = w_avg_done && w_rat_done;

    // Saturate the quotients; report zero when nothing was compared.
    always_comb begin
        n_avg   = '0;
        n_ratio = '0;
        if (r_snap.compared != '0) begin
            n_avg   = (w_avg_q > {{(DIV_W-AVG_W){1'b0}}, AVG_MAX})
                    ? AVG_MAX : w_avg_q[AVG_W-1:0];
            n_ratio = (w_rat_q > {{(DIV_W-RATIO_W){1'b0}}, RATIO_MAX})
                    ? RATIO_MAX : w_rat_q[RATIO_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && i_kind && i_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_fin.valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rows <= '0;
            r_prev_cols <= '0;
            r_cur_cols  <= '0;
            r_row_off   <= '0;
            r_thr       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PREV_ROWS: r_prev_rows <= i_cfg_data[5:0];
                CFG_PREV_COLS: r_prev_cols <= i_cfg_data[4:0];
                CFG_CUR_COLS:  r_cur_cols  <= i_cfg_data[4:0];
                CFG_ROW_OFF:   r_row_off   <= i_cfg_data[5:0];
                CFG_THRESHOLD: r_thr       <= i_cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold the grid totals while the divide runs.
    always_ff @(posedge i_clk) begin
        if (w_fin.valid) begin
            r_snap <= w_fin;
        end
    end

    // Result strobe lasts one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_div_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_out_cmp   <= r_snap.compared;
            r_out_mat   <= r_snap.matched;
            r_out_sum   <= r_snap.total;
            r_out_avg   <= n_avg;
            r_out_ratio <= n_ratio;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_compared_cells   = r_out_cmp;
    assign o_matched_cells    = r_out_mat;
    assign o_total_distance   = r_out_sum;
    assign o_average_distance = r_out_avg;
    assign o_match_ratio      = r_out_ratio;

endmodule

// ===== rtl/ghod_chk.sv =====
// ----------------------------------------------------------------------------
// ghod_chk
// Port-level checks of the grid hash compare, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ghod_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_start,
    input logic                             o_busy,
    input logic                             i_kind,
    input logic                             i_last,
    input logic                             o_valid,
    input logic [ghod_pkg::CNT_W-1:0]       o_compared_cells,
    input logic [ghod_pkg::CNT_W-1:0]       o_matched_cells,
    input logic [ghod_pkg::SUM_W-1:0]       o_total_distance,
    input logic [ghod_pkg::AVG_W-1:0]       o_average_distance,
    input logic [ghod_pkg::RATIO_W-1:0]     o_match_ratio
);
    import ghod_pkg::*;

    // A closing compare transaction must lock out new cells.
    `GHOD_ASSERT_NEXT(a_last_sets_busy, i_clk, i_rst_n, i_start && !o_busy && i_kind && i_last, o_busy)

    // Results only come out of a busy span, and never twice in a row.
    `GHOD_ASSERT_SAME(a_valid_after_busy, i_clk, i_rst_n, o_valid, $past(o_busy))
    `GHOD_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)

    // An empty grid reports all zeros.
    `GHOD_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_valid && o_compared_cells == '0, o_matched_cells == '0 && o_total_distance == '0 && o_average_distance == '0 && o_match_ratio == '0)

    // Matches never exceed compares, and the ratio never exceeds one.
    `GHOD_ASSERT_SAME(a_ratio_bound, i_clk, i_rst_n, o_valid, o_matched_cells <= o_compared_cells && o_match_ratio <= RATIO_MAX)

endmodule

bind grid_hash_offset_delta_core ghod_chk u_ghod_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_start            (i_start),
    .o_busy             (o_busy),
    .i_kind             (i_kind),
    .i_last             (i_last),
    .o_valid            (o_valid),
    .o_compared_cells   (o_compared_cells),
    .o_matched_cells    (o_matched_cells),
    .o_total_distance   (o_total_distance),
    .o_average_distance (o_average_distance),
    .o_match_ratio      (o_match_ratio)
);

// ===== verif/grid_hash_offset_delta_checker.sv =====
// ----------------------------------------------------------------------------
// grid_hash_offset_delta_checker
// Watches the cell, register and result channels of the grid hash compare,
// keeps its own copy of the hash store, registers and grid totals, and checks
// every result against the oldest outstanding grid prediction.
// ----------------------------------------------------------------------------
module grid_hash_offset_delta_checker #(
    parameter int MAX_ROWS  = ghod_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = ghod_pkg::DEF_MAX_COLS,
    parameter int HASH_BITS = ghod_pkg::DEF_HASH_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic                             i_kind,
    input  logic [ghod_pkg::ROW_W-1:0]       i_row,
    input  logic [ghod_pkg::COL_W-1:0]       i_col,
    input  logic [ghod_pkg::HASH_W-1:0]      i_hash,
    input  logic                             i_last,
    input  logic                             i_cfg_we,
    input  logic [ghod_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ghod_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    input  logic [ghod_pkg::CNT_W-1:0]       i_compared_cells,
    input  logic [ghod_pkg::CNT_W-1:0]       i_matched_cells,
    input  logic [ghod_pkg::SUM_W-1:0]       i_total_distance,
    input  logic [ghod_pkg::AVG_W-1:0]       i_average_distance,
    input  logic [ghod_pkg::RATIO_W-1:0]     i_match_ratio,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ghod_pkg::*;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic [HASH_W-1:0] HASH_MASK = {HASH_W{1'b1}} >> (HASH_W - HASH_BITS);
    localparam int COUNT_TOP = 1023;
    localparam int SUM_TOP = 65535;
    localparam longint unsigned AVG_TOP = 32767;
    localparam longint unsigned RATIO_TOP = 65536;
    localparam int PRINT_LIMIT = 200;

    typedef struct packed {
        logic [CNT_W-1:0]   compared;
        logic [CNT_W-1:0]   matched;
        logic [SUM_W-1:0]   total;
        logic [AVG_W-1:0]   average;
        logic [RATIO_W-1:0] ratio;
    } t_grid_totals;

    bit [HASH_W-1:0] hash_store [MAX_ROWS*MAX_COLS];
    int              dist_total;
    int              cells_compared;
    int              cells_matched;
    int              reg_prev_rows;
    int              reg_prev_cols;
    int              reg_cur_cols;
    int              reg_row_offset;
    int              reg_threshold;
    t_grid_totals    grid_totals_q [$];
    int              fail_count = 0;

    task automatic report(input string msg);
        // keep the log readable when a bug floods it; every one still counts
        if (fail_count < PRINT_LIMIT) begin
            $display("[%0t] grid totals mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    task automatic check_result();
        t_grid_totals want;
        if (grid_totals_q.size() == 0) begin
            report($sformatf("result with no grid outstanding (compared %0d)",
                             i_compared_cells));
            return;
        end
        want = grid_totals_q.pop_front();
        check_field("compared_cells", 32'(i_compared_cells), 32'(want.compared));
        check_field("matched_cells", 32'(i_matched_cells), 32'(want.matched));
        check_field("total_distance", 32'(i_total_distance), 32'(want.total));
        check_field("average_distance", 32'(i_average_distance), 32'(want.average));
        check_field("match_ratio", 32'(i_match_ratio), 32'(want.ratio));
    endtask

    // Fold one accepted cell into the grid totals; close the grid on last.
    task automatic fold_cell(input logic kind, input int row, input int col,
                             input logic [HASH_W-1:0] hash, input logic last);
        int              prev_row;
        int              rows_in;
        int              cols_in;
        int              cell_dist;
        longint unsigned avg;
        longint unsigned ratio;
        t_grid_totals    totals;
        if (kind == KIND_LOAD) begin
            if (row < MAX_ROWS && col < MAX_COLS) begin
                hash_store[row*MAX_COLS + col] = hash & HASH_MASK;
            end
            return;
        end
        prev_row = row + reg_row_offset;
        rows_in = (reg_prev_rows < MAX_ROWS) ? reg_prev_rows : MAX_ROWS;
        cols_in = (reg_prev_cols < reg_cur_cols) ? reg_prev_cols : reg_cur_cols;
        if (cols_in > MAX_COLS) begin
            cols_in = MAX_COLS;
        end
        if (prev_row >= 0 && prev_row < rows_in && col < cols_in) begin
            cell_dist = $countones((hash_store[prev_row*MAX_COLS + col] ^ hash) & HASH_MASK);
            dist_total = dist_total + cell_dist;
            if (dist_total > SUM_TOP) begin
                dist_total = SUM_TOP;
            end
            if (cells_compared < COUNT_TOP) begin
                cells_compared++;
            end
            if (cell_dist <= reg_threshold && cells_matched < COUNT_TOP) begin
                cells_matched++;
            end
        end
        if (!last) begin
            return;
        end
        avg = 0;
        ratio = 0;
        if (cells_compared != 0) begin
            avg = (longint'(dist_total) << 8) / cells_compared;
            ratio = (longint'(cells_matched) << 16) / cells_compared;
            if (avg > AVG_TOP) begin
                avg = AVG_TOP;
            end
            if (ratio > RATIO_TOP) begin
                ratio = RATIO_TOP;
            end
        end
        totals.compared = CNT_W'(cells_compared);
        totals.matched = CNT_W'(cells_matched);
        totals.total = SUM_W'(dist_total);
        totals.average = AVG_W'(avg);
        totals.ratio = RATIO_W'(ratio);
        grid_totals_q = {grid_totals_q, totals};
        dist_total = 0;
        cells_compared = 0;
        cells_matched = 0;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (t_cfg_idx'(idx))
            CFG_PREV_ROWS: reg_prev_rows = int'(data[5:0]);
            CFG_PREV_COLS: reg_prev_cols = int'(data[4:0]);
            CFG_CUR_COLS:  reg_cur_cols = int'(data[4:0]);
            CFG_ROW_OFF:   reg_row_offset = int'($signed(data[5:0]));
            CFG_THRESHOLD: reg_threshold = int'(data[6:0]);
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dist_total = 0;
            cells_compared = 0;
            cells_matched = 0;
            reg_prev_rows = 0;
            reg_prev_cols = 0;
            reg_cur_cols = 0;
            reg_row_offset = 0;
            reg_threshold = 0;
            grid_totals_q.delete();
        end else begin
            if (i_valid === 1'b1) begin
                check_result();
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                fold_cell(i_kind, int'(i_row), int'(i_col), i_hash, i_last);
            end
            if (i_cfg_we === 1'b1) begin
                apply_reg(i_cfg_idx, i_cfg_data);
            end
        end
        o_pending <= grid_totals_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== verif/grid_hash_offset_delta_core_tb.sv =====
// ----------------------------------------------------------------------------
// grid_hash_offset_delta_core_tb
// Drives cell transactions and register writes into the grid hash compare
// and gives the verdict. A directed part covers empty grids, skipped rows and
// columns, extreme distances, oversized dimensions and a long back-to-back
// grid; random previous/current grid sequences with random gaps follow. All
// checking lives in the checker instance and in the port checks bound to the block.
// ----------------------------------------------------------------------------
module grid_hash_offset_delta_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ghod_pkg::*;

    localparam int CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_COMPARE = 1'b1;
    // Let the pipeline run dry after the result strobe; leave margin on top.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 500;
    localparam int LONG_CELLS = 200;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic                  i_kind = 1'b0;
    logic [ROW_W-1:0]      i_row = '0;
    logic [COL_W-1:0]      i_col = '0;
    logic [HASH_W-1:0]     i_hash = '0;
    logic                  i_last = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    logic [CNT_W-1:0]      o_compared_cells;
    logic [CNT_W-1:0]      o_matched_cells;
    logic [SUM_W-1:0]      o_total_distance;
    logic [AVG_W-1:0]      o_average_distance;
    logic [RATIO_W-1:0]    o_match_ratio;

    int                    fail_count;
    int                    pending_grids;
    int unsigned           cycle_count = 0;

    // Stimulus-side view of the registers and of what has been loaded, used
    // only to shape cells and to keep compares off never-loaded entries.
    int                    cfg_prev_rows = 0;
    int                    cfg_prev_cols = 0;
    int                    cfg_cur_cols = 0;
    int                    cfg_row_offset = 0;
    int                    cfg_threshold = 0;
    bit                    loaded_cell [CELLS];
    logic [HASH_W-1:0]     cell_image [CELLS];
    bit                    burst = 1'b0;
    int                    items_sent = 0;

    grid_hash_offset_delta_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_kind             (i_kind),
        .i_row              (i_row),
        .i_col              (i_col),
        .i_hash             (i_hash),
        .i_last             (i_last),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_compared_cells   (o_compared_cells),
        .o_matched_cells    (o_matched_cells),
        .o_total_distance   (o_total_distance),
        .o_average_distance (o_average_distance),
        .o_match_ratio      (o_match_ratio)
    );

    grid_hash_offset_delta_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .i_busy             (o_busy),
        .i_kind             (i_kind),
        .i_row              (i_row),
        .i_col              (i_col),
        .i_hash             (i_hash),
        .i_last             (i_last),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (o_valid),
        .i_compared_cells   (o_compared_cells),
        .i_matched_cells    (o_matched_cells),
        .i_total_distance   (o_total_distance),
        .i_average_distance (o_average_distance),
        .i_match_ratio      (o_match_ratio),
        .o_fail_count       (fail_count),
        .o_pending          (pending_grids)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: abort a hung run well past the slowest legal one.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Tell whether a compare at (row, col) reads the store under the current
    // registers, and where.
    function automatic bit store_read(input int row, input int col, output int addr);
        int prev_row;
        int rows_in;
        int cols_in;
        prev_row = row + cfg_row_offset;
        rows_in = (cfg_prev_rows < DEF_MAX_ROWS) ? cfg_prev_rows : DEF_MAX_ROWS;
        cols_in = (cfg_prev_cols < cfg_cur_cols) ? cfg_prev_cols : cfg_cur_cols;
        if (cols_in > DEF_MAX_COLS) begin
            cols_in = DEF_MAX_COLS;
        end
        addr = prev_row * DEF_MAX_COLS + col;
        return prev_row >= 0 && prev_row < rows_in && col < cols_in;
    endfunction

    function automatic int pick_one(input int a, input int b, input int c, input int d);
        case ($urandom_range(0, 3))
            0: return a;
            1: return b;
            2: return c;
            default: return d;
        endcase
    endfunction

    // Present one cell transaction after a random gap and hold it until the
    // block takes it. Leave start high on return so back-to-back cells stream.
    task automatic send_cell(input logic kind, input int row, input int col,
                             input logic [HASH_W-1:0] hash, input logic last);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_kind <= kind;
        i_row <= ROW_W'(row);
        i_col <= COL_W'(col);
        i_hash <= hash;
        i_last <= last;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        items_sent++;
        if (kind == KIND_LOAD) begin
            loaded_cell[row*DEF_MAX_COLS + col] = 1'b1;
            cell_image[row*DEF_MAX_COLS + col] = hash;
        end
    endtask

    // Random current cell: load its partner first if it was never written,
    // then pick a hash near, far from or unrelated to the stored one.
    task automatic random_compare(input int row, input int col, input logic last);
        int                addr;
        int                pick;
        int                flips;
        int                bit_idx;
        logic [HASH_W-1:0] hash;
        hash = {$urandom, $urandom};
        if (store_read(row, col, addr)) begin
            if (!loaded_cell[addr]) begin
                send_cell(KIND_LOAD, addr / DEF_MAX_COLS, col, {$urandom, $urandom},
                          1'($urandom_range(0, 1)));
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                // flip a few bits so distances straddle the threshold
                hash = cell_image[addr];
                flips = $urandom_range(0, (cfg_threshold + 2 > 64) ? 64 : cfg_threshold + 2);
                repeat (flips) begin
                    bit_idx = $urandom_range(0, HASH_W - 1);
                    hash[bit_idx] = ~hash[bit_idx];
                end
            end else if (pick == 7) begin
                hash = ~cell_image[addr];
            end else if (pick > 7) begin
                hash = cell_image[addr];
            end
        end
        send_cell(KIND_COMPARE, row, col, hash, last);
    endtask

    // Drop start and hold off until every grid result is in, then let the
    // pipeline run dry before touching the registers.
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_grids != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input int prev_rows, input int prev_cols,
                                input int cur_cols, input int row_offset,
                                input int threshold);
        write_reg(CFG_PREV_ROWS, CFG_DATA_W'(prev_rows & 'h3F));
        write_reg(CFG_PREV_COLS, CFG_DATA_W'(prev_cols & 'h1F));
        write_reg(CFG_CUR_COLS, CFG_DATA_W'(cur_cols & 'h1F));
        write_reg(CFG_ROW_OFF, CFG_DATA_W'(row_offset & 'h3F));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(threshold & 'h7F));
        i_cfg_we <= 1'b0;
        cfg_prev_rows = prev_rows;
        cfg_prev_cols = prev_cols;
        cfg_cur_cols = cur_cols;
        cfg_row_offset = row_offset;
        cfg_threshold = threshold;
    endtask

    initial begin
        int                item_base;
        int                prev_rows;
        int                prev_cols;
        int                cur_cols;
        int                row_offset;
        int                threshold;
        int                load_rows;
        int                load_cols;
        int                grid_rows;
        int                grid_cols;
        int                grid_cells;
        int                stop_at;
        bit                spread;
        bit                drop_last;
        logic [HASH_W-1:0] seed_hash;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed --------------------------------------------------------
        // Registers still at reset: a last on a load is ignored, and a grid
        // with nothing compared reports all zeros.
        send_cell(KIND_LOAD, 3, 7, '1, 1'b1);
        send_cell(KIND_COMPARE, 0, 0, 64'h0123_4567_89AB_CDEF, 1'b1);
        drain();

        // 2x2 grids, no offset, exact matches only.
        program_regs(2, 2, 2, 0, 0);
        send_cell(KIND_LOAD, 0, 0, '0, 1'b0);
        send_cell(KIND_LOAD, 0, 1, '1, 1'b1);
        send_cell(KIND_LOAD, 1, 0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_cell(KIND_LOAD, 1, 1, 64'h8000_0000_0000_0001, 1'b0);
        send_cell(KIND_COMPARE, 0, 2, '1, 1'b0);                    // column past width
        send_cell(KIND_COMPARE, 2, 0, '1, 1'b0);                    // row past grid
        send_cell(KIND_COMPARE, 0, 0, '0, 1'b0);                    // distance zero
        send_cell(KIND_COMPARE, 0, 1, '0, 1'b0);                    // full distance
        send_cell(KIND_COMPARE, 1, 0, 64'h5555_5555_5555_5555, 1'b0);
        send_cell(KIND_COMPARE, 1, 1, 64'h0000_0000_0000_0001, 1'b1);
        drain();

        // Negative offset and a threshold above the hash width.
        program_regs(2, 2, 2, -1, 127);
        send_cell(KIND_COMPARE, 0, 0, '1, 1'b0);                    // maps above row 0
        send_cell(KIND_COMPARE, 1, 1, '0, 1'b0);
        send_cell(KIND_COMPARE, 1, 0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        drain();

        // Oversized dimensions clamp to the store; largest positive offset.
        program_regs(63, 31, 31, 31, 64);
        send_cell(KIND_LOAD, 31, 15, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
        send_cell(KIND_COMPARE, 0, 15, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
        send_cell(KIND_COMPARE, 1, 0, '0, 1'b0);                    // lands on row 32
        send_cell(KIND_COMPARE, 1, 15, '0, 1'b1);
        drain();

        // One long back-to-back grid at full distance on a single cell.
        program_regs(1, 1, 1, 0, 64);
        seed_hash = {$urandom, $urandom};
        send_cell(KIND_LOAD, 0, 0, seed_hash, 1'b0);
        burst = 1'b1;
        for (int n = 0; n < LONG_CELLS; n++) begin
            send_cell(KIND_COMPARE, 0, 0, ~seed_hash, 1'(n == LONG_CELLS - 1));
        end
        burst = 1'b0;
        drain();

        // ---- random grid sequences ------------------------------------------
        item_base = items_sent;
        while (items_sent - item_base < RANDOM_ITEMS) begin
            // Mostly small grids that load fully; now and then extreme
            // registers with cells scattered over the whole store.
            spread = ($urandom_range(0, 9) >= 7);
            if (!spread) begin
                prev_rows = $urandom_range(1, 6);
                prev_cols = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
                cur_cols = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
                row_offset = $urandom_range(0, 6) - 3;
                threshold = pick_one(0, 64, $urandom_range(0, 127), $urandom_range(0, 40));
            end else begin
                prev_rows = pick_one(0, 32, 63, $urandom_range(0, 63));
                prev_cols = pick_one(0, 16, 31, $urandom_range(0, 31));
                cur_cols = pick_one(0, 16, 31, $urandom_range(0, 31));
                row_offset = pick_one(-32, -31, 31, $urandom_range(0, 63) - 32);
                threshold = pick_one(0, 64, 127, $urandom_range(0, 127));
            end
            program_regs(prev_rows, prev_cols, cur_cols, row_offset, threshold);
            burst = ($urandom_range(0, 3) == 0);

            // Load the previous grid.
            if (!spread) begin
                load_rows = (prev_rows < DEF_MAX_ROWS) ? prev_rows : DEF_MAX_ROWS;
                load_cols = (prev_cols < DEF_MAX_COLS) ? prev_cols : DEF_MAX_COLS;
                for (int r = 0; r < load_rows; r++) begin
                    for (int c = 0; c < load_cols; c++) begin
                        send_cell(KIND_LOAD, r, c, {$urandom, $urandom},
                                  1'($urandom_range(0, 1)));
                    end
                end
            end else begin
                repeat (12) begin
                    send_cell(KIND_LOAD, $urandom_range(0, DEF_MAX_ROWS - 1),
                              $urandom_range(0, DEF_MAX_COLS - 1), {$urandom, $urandom},
                              1'($urandom_range(0, 1)));
                end
            end

            // One to three current grids against the same store.
            repeat ($urandom_range(1, 3)) begin
                drop_last = ($urandom_range(0, 9) == 0);
                if (!spread) begin
                    grid_rows = $urandom_range(1, prev_rows + 2);
                    grid_cols = ((cur_cols == 0) ? 1 : cur_cols) + $urandom_range(0, 1);
                    grid_cells = grid_rows * grid_cols;
                    // occasionally cut the grid short
                    stop_at = ($urandom_range(0, 9) == 0) ?
                              $urandom_range(0, grid_cells - 1) : grid_cells - 1;
                    for (int k = 0; k <= stop_at; k++) begin
                        // stray loads interleaved with the current grid
                        if ($urandom_range(0, 11) == 0) begin
                            send_cell(KIND_LOAD, $urandom_range(0, DEF_MAX_ROWS - 1),
                                      $urandom_range(0, DEF_MAX_COLS - 1),
                                      {$urandom, $urandom}, 1'($urandom_range(0, 1)));
                        end
                        random_compare(k / grid_cols, k % grid_cols,
                                       1'(k == stop_at && !drop_last));
                    end
                end else begin
                    for (int k = 0; k < 16; k++) begin
                        random_compare($urandom_range(0, DEF_MAX_ROWS - 1),
                                       $urandom_range(0, DEF_MAX_COLS - 1),
                                       1'(k == 15 && !drop_last));
                    end
                end
            end
            burst = 1'b0;
            drain();
        end

        // Close out any grid left open by a dropped last.
        random_compare(0, 0, 1'b1);
        drain();

        if (fail_count == 0 && pending_grids == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
